[sv/sit_pkg.sv]
// types and constants for the segment intersection test
// shared by sit_div and segment_intersection_test; no dependencies
`default_nettype none
package sit_pkg;

  localparam int W     = 32;          // coordinate width
  localparam int EW    = W + 1;       // difference of two coordinates
  localparam int PW    = 2 * EW;      // product of two differences
  localparam int NW    = PW + 1;      // numerator and denominator
  localparam int XW    = W + NW;      // dividend: step times numerator
  localparam int LO_W  = (NW + 1) / 2;
  localparam int HI_W  = NW - LO_W;
  localparam int LIM_W = 16;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(7);

  typedef struct packed {
    logic signed [W-1:0] first_start_x;
    logic signed [W-1:0] first_step_x;
    logic signed [W-1:0] first_start_y;
    logic signed [W-1:0] first_step_y;
    logic signed [W-1:0] second_start_x;
    logic signed [W-1:0] second_step_x;
    logic signed [W-1:0] second_start_y;
    logic signed [W-1:0] second_step_y;
  } src_word_t;

  typedef struct packed {
    logic                hit;
    logic signed [W-1:0] hit_x;
    logic signed [W-1:0] hit_y;
  } res_word_t;

  // one word in flight through the divider
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                neg_x;
    logic                neg_y;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic [NW-1:0]       den;
    logic [XW-1:0]       rem_x;
    logic [XW-1:0]       rem_y;
    logic [W-1:0]        quo_x;
    logic [W-1:0]        quo_y;
  } div_t;

endpackage
`default_nettype wire

[sv/sit_div.sv]
// pipelined restoring divider, one quotient bit per stage, x and y side by side
// depends on sit_pkg
`default_nettype none
module sit_div import sit_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire div_t din,
  output div_t      dout
);

  div_t stage [0:W];

  assign stage[0] = din;

  for (genvar i = 0; i < W; i++) begin : g_step
    localparam int B = W - 1 - i;
    logic [XW-1:0] shifted;
    div_t          step;

    always_comb begin
      shifted = XW'(stage[i].den) << B;
      step    = stage[i];
      if (stage[i].rem_x >= shifted) begin
        step.rem_x    = stage[i].rem_x - shifted;
        step.quo_x[B] = 1'b1;
      end
      if (stage[i].rem_y >= shifted) begin
        step.rem_y    = stage[i].rem_y - shifted;
        step.quo_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage[i+1].valid <= 1'b0;
      end else if (en) begin
        stage[i+1] <= step;
      end
    end
  end

  assign dout = stage[W];

endmodule
`default_nettype wire

[sv/segment_intersection_test.sv]
// segment intersection test, top level
// six front stages, the 32-stage divider (one quotient bit per stage) and the output
// register; one word per cycle sustained while src_stall stays low
// synchronous reset clears all valid bits and sets near_zero_limit to 7
// depends on sit_pkg and sit_div
`default_nettype none
module segment_intersection_test import sit_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [LIM_W-1:0] cfg_wdata,
  input  wire logic             src_valid,
  output logic                  src_stall,
  input  wire src_word_t        src_word,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_word_t             res_word
);

  function automatic logic in_unit(logic signed [NW-1:0] n, logic signed [NW-1:0] d);
    logic signed [NW:0] nn;
    logic signed [NW:0] dd;
    logic signed [NW:0] diff;
    nn   = d[NW-1] ? -(NW+1)'(n) : (NW+1)'(n);
    dd   = d[NW-1] ? -(NW+1)'(d) : (NW+1)'(d);
    diff = dd - nn;
    return !nn[NW] && !diff[NW];
  endfunction

  function automatic logic [NW-1:0] mag(logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  logic [LIM_W-1:0] near_zero_limit;
  logic             en;
  logic             skid_full;

  assign en        = !skid_full;
  assign src_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= LIM_RESET;
    end else if (cfg_we) begin
      near_zero_limit <= cfg_wdata;
    end
  end

  // stage 1: differences and near-zero test
  logic                 s1_valid;
  logic                 s1_near;
  src_word_t            s1_w;
  logic signed [EW-1:0] s1_ex;
  logic signed [EW-1:0] s1_ey;
  logic signed [EW-1:0] b1_ext;
  logic signed [EW-1:0] lim_ext;

  assign b1_ext  = EW'(src_word.first_step_x);
  assign lim_ext = $signed(EW'(near_zero_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= src_valid;
      s1_w     <= src_word;
      s1_ex    <= EW'(src_word.second_start_x) - EW'(src_word.first_start_x);
      s1_ey    <= EW'(src_word.second_start_y) - EW'(src_word.first_start_y);
      s1_near  <= (b1_ext < lim_ext) && (-b1_ext < lim_ext);
    end
  end

  // stage 2: cross products
  logic                 s2_valid;
  logic                 s2_near;
  src_word_t            s2_w;
  logic signed [EW-1:0] s2_ex;
  logic signed [PW-1:0] s2_b1d2, s2_d1b2, s2_d2ex, s2_b2ey, s2_d1ex, s2_b1ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_near  <= s1_near;
      s2_w     <= s1_w;
      s2_ex    <= s1_ex;
      s2_b1d2  <= EW'(s1_w.first_step_x) * EW'(s1_w.second_step_y);
      s2_d1b2  <= EW'(s1_w.first_step_y) * EW'(s1_w.second_step_x);
      s2_d2ex  <= EW'(s1_w.second_step_y) * s1_ex;
      s2_b2ey  <= EW'(s1_w.second_step_x) * s1_ey;
      s2_d1ex  <= EW'(s1_w.first_step_y) * s1_ex;
      s2_b1ey  <= EW'(s1_w.first_step_x) * s1_ey;
    end
  end

  // stage 3: fractions for both parameters
  logic                 s3_valid;
  logic                 s3_ok;
  src_word_t            s3_w;
  logic signed [NW-1:0] s3_n1, s3_d1, s3_n2, s3_d2;
  logic signed [NW-1:0] det;

  assign det = NW'(s2_b1d2) - NW'(s2_d1b2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      s3_w     <= s2_w;
      if (s2_near) begin
        s3_ok <= (s2_w.second_step_x != '0) && (s2_w.first_step_y != '0);
        s3_n1 <= NW'(s2_b2ey) - NW'(s2_d2ex);
        s3_d1 <= NW'(s2_d1b2);
        s3_n2 <= -NW'(s2_ex);
        s3_d2 <= NW'(s2_w.second_step_x);
      end else begin
        s3_ok <= (s2_w.first_step_x != '0) && (det != '0);
        s3_n1 <= NW'(s2_d2ex) - NW'(s2_b2ey);
        s3_d1 <= det;
        s3_n2 <= NW'(s2_d1ex) - NW'(s2_b1ey);
        s3_d2 <= det;
      end
    end
  end

  // stage 4: interval test and magnitudes
  logic                s4_valid;
  logic                s4_hit;
  logic                s4_neg_x, s4_neg_y;
  logic signed [W-1:0] s4_a1, s4_c1;
  logic [NW-1:0]       s4_n1m, s4_d1m;
  logic [W-1:0]        s4_b1m, s4_dym;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
      s4_hit   <= s3_ok && in_unit(s3_n1, s3_d1) && in_unit(s3_n2, s3_d2);
      s4_neg_x <= s3_w.first_step_x[W-1] ^ s3_n1[NW-1] ^ s3_d1[NW-1];
      s4_neg_y <= s3_w.first_step_y[W-1] ^ s3_n1[NW-1] ^ s3_d1[NW-1];
      s4_a1    <= s3_w.first_start_x;
      s4_c1    <= s3_w.first_start_y;
      s4_n1m   <= mag(s3_n1);
      s4_d1m   <= mag(s3_d1);
      s4_b1m   <= s3_w.first_step_x[W-1] ? W'(-s3_w.first_step_x) : W'(s3_w.first_step_x);
      s4_dym   <= s3_w.first_step_y[W-1] ? W'(-s3_w.first_step_y) : W'(s3_w.first_step_y);
    end
  end

  // stage 5: partial products of step times numerator
  logic                 s5_valid, s5_hit, s5_neg_x, s5_neg_y;
  logic signed [W-1:0]  s5_a1, s5_c1;
  logic [NW-1:0]        s5_d1m;
  logic [W+LO_W-1:0]    s5_xlo, s5_ylo;
  logic [W+HI_W-1:0]    s5_xhi, s5_yhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
      s5_hit   <= s4_hit;
      s5_neg_x <= s4_neg_x;
      s5_neg_y <= s4_neg_y;
      s5_a1    <= s4_a1;
      s5_c1    <= s4_c1;
      s5_d1m   <= s4_d1m;
      s5_xlo   <= (W+LO_W)'(s4_b1m) * (W+LO_W)'(s4_n1m[LO_W-1:0]);
      s5_xhi   <= (W+HI_W)'(s4_b1m) * (W+HI_W)'(s4_n1m[NW-1:LO_W]);
      s5_ylo   <= (W+LO_W)'(s4_dym) * (W+LO_W)'(s4_n1m[LO_W-1:0]);
      s5_yhi   <= (W+HI_W)'(s4_dym) * (W+HI_W)'(s4_n1m[NW-1:LO_W]);
    end
  end

  // stage 6: full dividends, handed to the divider
  div_t div_in;
  div_t div_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in.valid <= 1'b0;
    end else if (en) begin
      div_in.valid   <= s5_valid;
      div_in.hit     <= s5_hit;
      div_in.neg_x   <= s5_neg_x;
      div_in.neg_y   <= s5_neg_y;
      div_in.start_x <= s5_a1;
      div_in.start_y <= s5_c1;
      div_in.den     <= s5_d1m;
      div_in.rem_x   <= XW'(s5_xlo) + (XW'(s5_xhi) << LO_W);
      div_in.rem_y   <= XW'(s5_ylo) + (XW'(s5_yhi) << LO_W);
      div_in.quo_x   <= '0;
      div_in.quo_y   <= '0;
    end
  end

  sit_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (div_in),
    .dout (div_out)
  );

  // final: sign, offset, saturate
  localparam logic signed [W+1:0] SAT_HI = (W+2)'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [W+1:0] SAT_LO = -SAT_HI - (W+2)'(1);

  logic signed [W+1:0] qx, qy, px, py;
  res_word_t           fin;

  always_comb begin
    qx = div_out.neg_x ? -$signed({2'b00, div_out.quo_x}) : $signed({2'b00, div_out.quo_x});
    qy = div_out.neg_y ? -$signed({2'b00, div_out.quo_y}) : $signed({2'b00, div_out.quo_y});
    px = qx + (W+2)'(div_out.start_x);
    py = qy + (W+2)'(div_out.start_y);
    fin = '0;
    if (div_out.hit) begin
      fin.hit   = 1'b1;
      fin.hit_x = (px > SAT_HI) ? W'(SAT_HI) : (px < SAT_LO) ? W'(SAT_LO) : W'(px);
      fin.hit_y = (py > SAT_HI) ? W'(SAT_HI) : (py < SAT_LO) ? W'(SAT_LO) : W'(py);
    end
  end

  // output register with one skid entry
  res_word_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!res_stall) begin
        res_word  <= skid;
        skid_full <= 1'b0;
      end
    end else if (div_out.valid) begin
      if (res_valid && res_stall) begin
        skid      <= fin;
        skid_full <= 1'b1;
      end else begin
        res_word  <= fin;
        res_valid <= 1'b1;
      end
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[bench/segment_intersection_test_tb.sv]
// self-checking bench for segment_intersection_test: random and directed segment pairs,
// predicted with wide exact arithmetic, compared word by word at the result port
// depends on sit_pkg and the segment_intersection_test RTL
`timescale 1ns / 1ps
module segment_intersection_test_tb;
  import sit_pkg::*;

  typedef logic signed [191:0] big_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [LIM_W-1:0] cfg_wdata = '0;
  logic             src_valid = 1'b0;
  logic             src_stall;
  src_word_t        src_word = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_word_t        res_word;

  src_word_t        pending_words[$];
  res_word_t        expected_words[$];
  logic [LIM_W-1:0] limit_shadow = LIM_RESET;
  int               error_count = 0;
  int               src_gap = 0;
  int               res_gap = 0;
  int               hold_cnt = 0;
  bit               hold_done = 0;
  bit               quiet_mode = 0;
  int               results_seen = 0;
  int               idle_cycles = 0;

  segment_intersection_test u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_word (src_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word (res_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_word(src_word_t s);
    pending_words.insert(pending_words.size(), s);
  endfunction

  function automatic bit within_unit(big_t n, big_t d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return (n >= 0) && (d - n >= 0);
  endfunction

  function automatic logic signed [W-1:0] clamp_coord(big_t v);
    big_t hi;
    big_t lo;
    hi = big_t'(64'sh7fffffff);
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[W-1:0];
  endfunction

  function automatic res_word_t predict_crossing(src_word_t s, logic [LIM_W-1:0] lim_v);
    big_t a1, b1, c1, d1, a2, b2, c2, d2, ex, ey, lim, n1, n2, den1, den2, det;
    bit ok;
    res_word_t r;
    a1 = s.first_start_x;  b1 = s.first_step_x;
    c1 = s.first_start_y;  d1 = s.first_step_y;
    a2 = s.second_start_x; b2 = s.second_step_x;
    c2 = s.second_start_y; d2 = s.second_step_y;
    ex = a2 - a1;
    ey = c2 - c1;
    lim = big_t'({1'b0, lim_v});
    r = '0;
    if (b1 < lim && -b1 < lim) begin
      // first x step treated as zero: solve from the second segment's x first
      ok = (b2 != 0) && (d1 != 0);
      n2 = -ex;
      den2 = b2;
      n1 = ey * b2 - d2 * ex;
      den1 = b2 * d1;
    end else begin
      det = b1 * d2 - d1 * b2;
      ok = (b1 != 0) && (det != 0);
      n1 = d2 * ex - b2 * ey;
      n2 = d1 * ex - b1 * ey;
      den1 = det;
      den2 = det;
    end
    if (ok && within_unit(n1, den1) && within_unit(n2, den2)) begin
      r.hit = 1'b1;
      r.hit_x = clamp_coord(a1 + (b1 * n1) / den1);
      r.hit_y = clamp_coord(c1 + (d1 * n1) / den1);
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
  endfunction

  // well-formed pair: second start placed so the segments cross at k1/16 and k2/16
  function automatic src_word_t crossing_pair(bit tiny_step);
    src_word_t s;
    logic signed [63:0] qx, qy;
    int k1, k2;
    s = '0;
    k1 = $urandom_range(0, 20) - 2;
    k2 = $urandom_range(0, 20) - 2;
    s.first_start_x = rand_coord();
    s.first_start_y = rand_coord();
    s.first_step_x  = tiny_step ? $signed($urandom_range(0, 30)) - 15 : rand_coord();
    s.first_step_y  = rand_coord();
    s.second_step_x = rand_coord();
    s.second_step_y = rand_coord();
    qx = 64'(s.first_start_x) + ((64'(s.first_step_x) * k1) >>> 4);
    qy = 64'(s.first_start_y) + ((64'(s.first_step_y) * k1) >>> 4);
    s.second_start_x = W'(qx - ((64'(s.second_step_x) * k2) >>> 4));
    s.second_start_y = W'(qy - ((64'(s.second_step_y) * k2) >>> 4));
    return s;
  endfunction

  function automatic src_word_t random_pair();
    src_word_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return crossing_pair(1'b0);
    if (pick < 72) return crossing_pair(1'b1);
    s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (pick < 82) begin
      // parallel directions
      s.second_step_x = s.first_step_x;
      s.second_step_y = s.first_step_y;
    end else if (pick < 88) begin
      s.first_step_x = $signed($urandom_range(0, 30)) - 15;
      if ($urandom_range(0, 1)) s.second_step_x = '0;
      else s.first_step_y = '0;
    end
    return s;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_words.size() != 0 || src_valid)
      @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_shadow = v;
  endtask

  task automatic add_directed();
    src_word_t s;
    s = '0;
    queue_word(s);
    s = {8{32'sh8000_0000}};
    queue_word(s);
    s = {8{32'sh7fff_ffff}};
    queue_word(s);
    // crossing far out: position saturates high on x
    s = '0;
    s.first_start_x = 32'sh7fff_ffff;  s.first_step_x = 32'sh7fff_ffff;
    s.second_start_x = 32'sh7fff_ffff; s.second_step_x = 32'sh7fff_ffff;
    s.second_start_y = 32'sh0001_0000; s.second_step_y = -32'sh0002_0000;
    queue_word(s);
    // mirrored, saturates low
    s.first_start_x = 32'sh8000_0000;  s.first_step_x = 32'sh8000_0001;
    s.second_start_x = 32'sh8000_0000; s.second_step_x = 32'sh8000_0001;
    queue_word(s);
    // simple cross at the middle, then at both endpoints
    s = '0;
    s.first_step_x = 32'sh0002_0000;  s.first_step_y = 32'sh0002_0000;
    s.second_start_y = 32'sh0002_0000; s.second_step_x = 32'sh0002_0000;
    s.second_step_y = -32'sh0002_0000;
    queue_word(s);
    s.second_start_y = 32'sh0000_0000; s.second_step_y = 32'sh0000_0000;
    s.second_start_x = -32'sh0001_0000;
    queue_word(s);
    s.second_start_x = 32'sh0002_0000; s.second_start_y = 32'sh0002_0000;
    queue_word(s);
    // tiny first x step: alternate formulas, hit and zero divisors
    s = '0;
    s.first_step_x = 32'sh3; s.first_step_y = 32'sh0004_0000;
    s.second_start_x = -32'sh0001_0000; s.second_start_y = 32'sh0001_0000;
    s.second_step_x = 32'sh0002_0000;
    queue_word(s);
    s.second_step_x = '0;
    queue_word(s);
    s.second_step_x = 32'sh0002_0000; s.first_step_y = '0;
    queue_word(s);
    s.first_step_x = -32'sh6; s.first_step_y = 32'sh0004_0000;
    queue_word(s);
    // exactly zero first x step and parallel segments
    s.first_step_x = '0;
    queue_word(s);
    s = crossing_pair(1'b0);
    s.second_step_x = s.first_step_x; s.second_step_y = s.first_step_y;
    queue_word(s);
    repeat (6) queue_word(crossing_pair(1'b0));
    repeat (4) queue_word(crossing_pair(1'b1));
  endtask

  task automatic add_random(int n);
    repeat (n) queue_word(random_pair());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    add_random(150);
    write_limit(16'd0);
    add_directed();
    add_random(100);
    write_limit(16'hffff);
    quiet_mode = 1;
    add_random(100);
    wait_idle();
    quiet_mode = 0;
    write_limit(LIM_W'($urandom_range(1, 40)));
    add_directed();
    add_random(120);
    write_limit(16'd7);
    add_random(30);
    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  function automatic int pick_gap();
    int p;
    if (quiet_mode) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: word stays on the bus until accepted
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && !src_stall) begin
        expected_words.insert(expected_words.size(), predict_crossing(src_word, limit_shadow));
        void'(pending_words.pop_front());
      end
      if (!(src_valid && src_stall)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          src_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          src_word <= pending_words[0];
          src_valid <= 1'b1;
          src_gap <= pick_gap();
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    res_word_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          error_count = error_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (res_word.hit !== want.hit) begin
            $error("hit: expected %0d got %0d", want.hit, res_word.hit);
            error_count = error_count + 1;
          end
          if (res_word.hit_x !== want.hit_x) begin
            $error("hit_x: expected %h got %h", want.hit_x, res_word.hit_x);
            error_count = error_count + 1;
          end
          if (res_word.hit_y !== want.hit_y) begin
            $error("hit_y: expected %h got %h", want.hit_y, res_word.hit_y);
            error_count = error_count + 1;
          end
        end
      end
      if (!hold_done && results_seen == 40) begin
        // long hold-off so the pipeline fills and backs up to the source
        hold_done <= 1;
        hold_cnt <= 300;
        res_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        res_stall <= 1'b1;
      end else if (res_gap > 0) begin
        res_gap <= res_gap - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        res_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((src_valid && !src_stall) || (res_valid && !res_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
